[hdl/ect_pkg.sv]
// ----------------------------------------------------------------------------
// ect_pkg: shared codes and control types for the event channel table
// Operation, error, channel state and status codes, plus the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ect_pkg;

  // operation codes
  localparam logic [2:0] FN_ALLOC  = 3'd0;
  localparam logic [2:0] FN_BIND   = 3'd1;
  localparam logic [2:0] FN_CLOSE  = 3'd2;
  localparam logic [2:0] FN_SEND   = 3'd3;
  localparam logic [2:0] FN_STATUS = 3'd4;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NO_FREE   = 3'd1;
  localparam logic [2:0] ERR_NOT_OPEN  = 3'd2;
  localparam logic [2:0] ERR_PEER_WAIT = 3'd3;
  localparam logic [2:0] ERR_UNCONN    = 3'd4;

  // channel states held in the table
  localparam logic [1:0] CS_FREE     = 2'd0;
  localparam logic [1:0] CS_RESERVED = 2'd1;
  localparam logic [1:0] CS_UNBOUND  = 2'd2;
  localparam logic [1:0] CS_INTER    = 2'd3;

  // status codes reported by a status query
  localparam logic [1:0] STAT_CLOSED  = 2'd0;
  localparam logic [1:0] STAT_UNBOUND = 2'd1;
  localparam logic [1:0] STAT_INTER   = 2'd2;

  // processor map after reset: domain d on processor d
  localparam logic [7:0] CPU_MAP_RESET = 8'hE4;

  // controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       scan_start;
    logic       scan_step;
    logic       scan_latch;
    logic       rd_local;
    logic       latch_local;
    logic       rd_remote;
    logic       latch_remote;
    logic       wr_local;
    logic       wr_remote;
    logic       clr_step;
    logic       set_err;
    logic [2:0] err;
    logic       out_load;
  } ect_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       in_valid;
    logic       clr_done;
    logic [2:0] func;
    logic       found;
    logic       exhausted;
    logic       scan_dom_ok;
    logic       local_ok;
    logic       peer_ok;
    logic [1:0] loc_state;
    logic       rem_range_ok;
    logic       rem_waiting;
    logic       rem_back;
    logic       out_free;
  } ect_stat_t;

endpackage

[hdl/ect_if.sv]
// ----------------------------------------------------------------------------
// ect_if: request and response channels of the event channel table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ect_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [1:0] caller_dom;
  logic [1:0] target_dom;
  logic [1:0] peer_dom;
  logic [4:0] peer_chan;
  logic [4:0] channel;

  modport source (
    output valid, func, caller_dom, target_dom, peer_dom, peer_chan, channel,
    input  ready
  );
  modport sink (
    input  valid, func, caller_dom, target_dom, peer_dom, peer_chan, channel,
    output ready
  );
endinterface

interface ect_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] error;
  logic [4:0] chan_out;
  logic [1:0] stat;
  logic [1:0] stat_dom;
  logic [4:0] stat_chan;
  logic       stat_pending;
  logic       notify_valid;
  logic [1:0] notify_cpu;

  modport source (
    output valid, error, chan_out, stat, stat_dom, stat_chan, stat_pending,
           notify_valid, notify_cpu,
    input  ready
  );
  modport sink (
    input  valid, error, chan_out, stat, stat_dom, stat_chan, stat_pending,
           notify_valid, notify_cpu,
    output ready
  );
endinterface

[hdl/ect_ctrl.sv]
// ----------------------------------------------------------------------------
// ect_ctrl: operation sequencer of the event channel table
// Clears the table after reset, then steps each operation through free search,
// local and peer reads, checks, writes and result hand-off.
// ----------------------------------------------------------------------------
module ect_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ect_pkg::ect_stat_t stat,
  output ect_pkg::ect_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_LOCAL    = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_REMOTE   = 4'd6;
  localparam logic [3:0] S_RCHECK   = 4'd7;
  localparam logic [3:0] S_WLOCAL   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          ect_pkg::FN_ALLOC, ect_pkg::FN_BIND: begin
            if (stat.scan_dom_ok) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              cmd.set_err = 1'b1;
              cmd.err     = ect_pkg::ERR_NO_FREE;
              state_next  = S_DONE;
            end
          end
          ect_pkg::FN_CLOSE, ect_pkg::FN_SEND, ect_pkg::FN_STATUS: begin
            if (stat.local_ok) begin
              cmd.rd_local = 1'b1;
              state_next   = S_LOCAL;
            end else begin
              cmd.set_err = (stat.func != ect_pkg::FN_STATUS);
              cmd.err     = (stat.func == ect_pkg::FN_CLOSE) ? ect_pkg::ERR_NOT_OPEN
                                                             : ect_pkg::ERR_UNCONN;
              state_next  = S_DONE;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // walk the domain's row until a free channel shows up or the row is exhausted
      S_SCAN: begin
        cmd.scan_latch = 1'b1;
        if (stat.found) begin
          if (stat.func == ect_pkg::FN_ALLOC) begin
            state_next = S_WLOCAL;
          end else if (!stat.peer_ok) begin
            cmd.set_err = 1'b1;
            cmd.err     = ect_pkg::ERR_PEER_WAIT;
            state_next  = S_DONE;
          end else begin
            cmd.rd_remote = 1'b1;
            state_next    = S_REMOTE;
          end
        end else if (stat.exhausted) begin
          cmd.set_err = 1'b1;
          cmd.err     = ect_pkg::ERR_NO_FREE;
          state_next  = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_LOCAL: begin
        cmd.latch_local = 1'b1;
        state_next = (stat.func == ect_pkg::FN_STATUS) ? S_DONE : S_CHECK;
      end
      // decide on the local entry of close and send
      S_CHECK: begin
        case (stat.func)
          ect_pkg::FN_CLOSE: begin
            if (stat.loc_state == ect_pkg::CS_FREE ||
                stat.loc_state == ect_pkg::CS_RESERVED) begin
              cmd.set_err = 1'b1;
              cmd.err     = ect_pkg::ERR_NOT_OPEN;
              state_next  = S_DONE;
            end else if (stat.loc_state == ect_pkg::CS_INTER && stat.rem_range_ok) begin
              cmd.rd_remote = 1'b1;
              state_next    = S_REMOTE;
            end else begin
              state_next = S_WLOCAL;
            end
          end
          ect_pkg::FN_SEND: begin
            if (stat.loc_state != ect_pkg::CS_INTER || !stat.rem_range_ok) begin
              cmd.set_err = 1'b1;
              cmd.err     = ect_pkg::ERR_UNCONN;
              state_next  = S_DONE;
            end else begin
              cmd.rd_remote = 1'b1;
              state_next    = S_REMOTE;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_REMOTE: begin
        cmd.latch_remote = 1'b1;
        state_next       = S_RCHECK;
      end
      // decide on the peer entry and, where the checks pass, update it
      S_RCHECK: begin
        case (stat.func)
          ect_pkg::FN_BIND: begin
            if (stat.rem_waiting) begin
              cmd.wr_remote = 1'b1;
              state_next    = S_WLOCAL;
            end else begin
              cmd.set_err = 1'b1;
              cmd.err     = ect_pkg::ERR_PEER_WAIT;
              state_next  = S_DONE;
            end
          end
          ect_pkg::FN_CLOSE: begin
            cmd.wr_remote = stat.rem_back;
            state_next    = S_WLOCAL;
          end
          ect_pkg::FN_SEND: begin
            cmd.wr_remote = 1'b1;
            state_next    = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_WLOCAL: begin
        cmd.wr_local = 1'b1;
        state_next   = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[hdl/ect_datapath.sv]
// ----------------------------------------------------------------------------
// ect_datapath: channel table memory, item registers and result register
// One table entry per domain and channel holds state, peer domain, peer
// channel and pending flag; one read and one write port per cycle.
// ----------------------------------------------------------------------------
module ect_datapath #(
  parameter int NUM_DOMAINS  = 4,
  parameter int NUM_CHANNELS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  ect_req_if.sink            req,
  ect_rsp_if.source          rsp,
  input  ect_pkg::ect_cmd_t  cmd,
  output ect_pkg::ect_stat_t stat
);

  localparam int TOTAL = NUM_DOMAINS * NUM_CHANNELS;
  localparam int AW    = $clog2(TOTAL);
  localparam int LCW   = $clog2(NUM_CHANNELS);
  localparam int SCW   = $clog2(NUM_CHANNELS + 1);

  typedef struct packed {
    logic [1:0]     state;
    logic [1:0]     ld;
    logic [LCW-1:0] lc;
    logic           pend;
  } entry_t;

  // table memory
  entry_t mem [0:TOTAL-1];
  entry_t rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // item and work registers
  logic [2:0]     func_r;
  logic [1:0]     caller_r;
  logic [1:0]     target_r;
  logic [1:0]     pdom_r;
  logic [4:0]     pchan_r;
  logic [4:0]     ch_r;
  logic [2:0]     err_r;
  logic [7:0]     cpu_map;
  entry_t         loc_ent;
  entry_t         rem_ent;
  logic [LCW-1:0] free_chan;
  logic [SCW-1:0] cnt;
  logic           chk_valid;
  logic [AW-1:0]  clr_addr;
  logic [LCW-1:0] clr_chan;
  logic           out_valid;

  // derived addresses
  logic [1:0]     scan_dom;
  logic [1:0]     loc_dom;
  logic [LCW-1:0] loc_chan;
  logic [1:0]     rem_dom;
  logic [LCW-1:0] rem_chan;
  logic [AW-1:0]  scan_addr;
  logic [AW-1:0]  loc_addr;
  logic [AW-1:0]  rem_addr;
  logic           is_scan_op;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] d,
                                               input logic [LCW-1:0] c);
    return AW'(32'(d) * NUM_CHANNELS + 32'(c));
  endfunction

  function automatic logic [1:0] cpu_of(input logic [7:0] map, input logic [1:0] d);
    return map[{d, 1'b0} +: 2];
  endfunction

  assign is_scan_op = (func_r == ect_pkg::FN_ALLOC) || (func_r == ect_pkg::FN_BIND);
  assign scan_dom   = (func_r == ect_pkg::FN_ALLOC) ? target_r : caller_r;
  assign loc_dom    = (func_r == ect_pkg::FN_ALLOC || func_r == ect_pkg::FN_STATUS)
                      ? target_r : caller_r;
  assign loc_chan   = is_scan_op ? free_chan : LCW'(ch_r);
  assign rem_dom    = (func_r == ect_pkg::FN_BIND) ? pdom_r : loc_ent.ld;
  assign rem_chan   = (func_r == ect_pkg::FN_BIND) ? LCW'(pchan_r) : loc_ent.lc;
  assign scan_addr  = slot_addr(scan_dom, LCW'(cnt));
  assign loc_addr   = slot_addr(loc_dom, loc_chan);
  assign rem_addr   = slot_addr(rem_dom, rem_chan);

  // read port select
  always_comb begin
    rd_en   = cmd.scan_step | cmd.rd_local | cmd.rd_remote;
    rd_addr = scan_addr;
    if (cmd.rd_local) begin
      rd_addr = loc_addr;
    end else if (cmd.rd_remote) begin
      rd_addr = rem_addr;
    end
  end

  // write port select and entry update
  always_comb begin
    wr_en   = cmd.clr_step | cmd.wr_local | cmd.wr_remote;
    wr_addr = rem_addr;
    wr_data = rem_ent;
    if (cmd.clr_step) begin
      wr_addr = clr_addr;
      wr_data = '{state: (clr_chan == '0) ? ect_pkg::CS_RESERVED : ect_pkg::CS_FREE,
                  ld: 2'b00, lc: '0, pend: 1'b0};
    end else if (cmd.wr_local) begin
      wr_addr = loc_addr;
      case (func_r)
        ect_pkg::FN_ALLOC: begin
          wr_data = '{state: ect_pkg::CS_UNBOUND, ld: pdom_r, lc: loc_ent.lc,
                      pend: loc_ent.pend};
        end
        ect_pkg::FN_BIND: begin
          wr_data = '{state: ect_pkg::CS_INTER, ld: pdom_r, lc: LCW'(pchan_r),
                      pend: loc_ent.pend};
        end
        default: begin
          wr_data = '{state: ect_pkg::CS_FREE, ld: loc_ent.ld, lc: loc_ent.lc,
                      pend: 1'b0};
        end
      endcase
    end else begin
      case (func_r)
        ect_pkg::FN_BIND: begin
          wr_data = '{state: ect_pkg::CS_INTER, ld: caller_r, lc: free_chan,
                      pend: rem_ent.pend};
        end
        ect_pkg::FN_CLOSE: begin
          wr_data = '{state: ect_pkg::CS_UNBOUND, ld: caller_r, lc: rem_ent.lc,
                      pend: rem_ent.pend};
        end
        default: begin
          wr_data = '{state: rem_ent.state, ld: rem_ent.ld, lc: rem_ent.lc,
                      pend: 1'b1};
        end
      endcase
    end
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // capture the item on transfer
  assign req.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (req.valid && cmd.take) begin
      func_r   <= req.func;
      caller_r <= req.caller_dom;
      target_r <= req.target_dom;
      pdom_r   <= req.peer_dom;
      pchan_r  <= req.peer_chan;
      ch_r     <= req.channel;
    end
  end

  // error code of the current item
  always_ff @(posedge clk) begin
    if (req.valid && cmd.take) begin
      err_r <= ect_pkg::ERR_OK;
    end else if (cmd.set_err) begin
      err_r <= cmd.err;
    end
  end

  // processor map register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_map <= ect_pkg::CPU_MAP_RESET;
    end else if (cfg_we) begin
      cpu_map <= cfg_data;
    end
  end

  // hold the entries read for this item
  always_ff @(posedge clk) begin
    if (cmd.scan_latch || cmd.latch_local) begin
      loc_ent <= rd_data;
    end
    if (cmd.scan_latch) begin
      free_chan <= LCW'(cnt - 1'b1);
    end
    if (cmd.latch_remote) begin
      rem_ent <= rd_data;
    end
  end

  // free search counter; data for channel cnt-1 arrives while cnt is read
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      cnt       <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.scan_step;
      if (cmd.scan_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // clearing pass counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_chan <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
      clr_chan <= (clr_chan == LCW'(NUM_CHANNELS - 1)) ? '0 : clr_chan + 1'b1;
    end
  end

  // status to the controller
  always_comb begin
    stat.in_valid     = req.valid;
    stat.clr_done     = (clr_addr == AW'(TOTAL - 1));
    stat.func         = func_r;
    stat.found        = chk_valid && (rd_data.state == ect_pkg::CS_FREE);
    stat.exhausted    = chk_valid && (rd_data.state != ect_pkg::CS_FREE) &&
                        (cnt == SCW'(NUM_CHANNELS));
    stat.scan_dom_ok  = 32'(scan_dom) < NUM_DOMAINS;
    stat.local_ok     = (32'(loc_dom) < NUM_DOMAINS) && (32'(ch_r) < NUM_CHANNELS);
    stat.peer_ok      = (32'(pdom_r) < NUM_DOMAINS) && (32'(pchan_r) < NUM_CHANNELS);
    stat.loc_state    = loc_ent.state;
    stat.rem_range_ok = (32'(loc_ent.ld) < NUM_DOMAINS) &&
                        (32'(loc_ent.lc) < NUM_CHANNELS);
    stat.rem_waiting  = (rem_ent.state == ect_pkg::CS_UNBOUND) &&
                        (rem_ent.ld == caller_r);
    stat.rem_back     = (rem_ent.state == ect_pkg::CS_INTER) &&
                        (rem_ent.ld == caller_r) && (32'(rem_ent.lc) == 32'(ch_r));
    stat.out_free     = !out_valid || rsp.ready;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;

  // assemble the result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.error        <= err_r;
      rsp.chan_out     <= (is_scan_op && err_r == ect_pkg::ERR_OK) ? 5'(free_chan) : 5'd0;
      rsp.stat         <= ect_pkg::STAT_CLOSED;
      rsp.stat_dom     <= 2'd0;
      rsp.stat_chan    <= 5'd0;
      rsp.stat_pending <= 1'b0;
      rsp.notify_valid <= 1'b0;
      rsp.notify_cpu   <= 2'd0;
      if (func_r == ect_pkg::FN_STATUS && stat.local_ok) begin
        rsp.stat_pending <= loc_ent.pend;
        if (loc_ent.state == ect_pkg::CS_UNBOUND) begin
          rsp.stat     <= ect_pkg::STAT_UNBOUND;
          rsp.stat_dom <= loc_ent.ld;
        end else if (loc_ent.state == ect_pkg::CS_INTER) begin
          rsp.stat      <= ect_pkg::STAT_INTER;
          rsp.stat_dom  <= loc_ent.ld;
          rsp.stat_chan <= 5'(loc_ent.lc);
        end
      end
      if (func_r == ect_pkg::FN_SEND && err_r == ect_pkg::ERR_OK &&
          cpu_of(cpu_map, caller_r) != cpu_of(cpu_map, loc_ent.ld)) begin
        rsp.notify_valid <= 1'b1;
        rsp.notify_cpu   <= cpu_of(cpu_map, loc_ent.ld);
      end
    end
  end

endmodule

[hdl/event_channel_table.sv]
// ----------------------------------------------------------------------------
// event_channel_table: inter-domain doorbell channel table
// Takes one channel operation (alloc, bind, close, send, status) on the req
// channel and returns one result on the rsp channel. Both are valid/ready;
// a transfer happens at a clock edge with valid and ready high.
// cfg_we/cfg_data write the processor map (two bits per domain). The user
// must write it only while no operation is in progress; it is not enforced.
// The table is one memory with a single read port, so the free search reads
// one channel per cycle.
// Reset: rst is synchronous; after it the table is cleared one entry per
// cycle over all NUM_DOMAINS*NUM_CHANNELS entries, with req.ready low
// (configuration writes are still taken).
// A stalled receiver holds the result in the output register; the next item
// is accepted meanwhile and waits for the register to drain before finishing.
// ----------------------------------------------------------------------------
module event_channel_table #(
  parameter int NUM_DOMAINS  = 4,
  parameter int NUM_CHANNELS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  ect_req_if.sink    req,
  ect_rsp_if.source  rsp
);

  ect_pkg::ect_cmd_t  cmd;
  ect_pkg::ect_stat_t stat;

  // sequencer
  ect_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // table and registers
  ect_datapath #(
    .NUM_DOMAINS  (NUM_DOMAINS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
